// ===== src/tfd_pkg.sv =====
package tfd_pkg;

  // input op codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // framing constants
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_MASK  = 8'h20;
  localparam logic [7:0] SUM_GOOD  = 8'hFF;
  localparam logic [7:0] DATA_TYPE = 8'h10;

  // bytes summed and bytes kept per frame
  localparam int CHECK_LEN = 8;
  localparam int STORE_LEN = 7;
  localparam int CNT_W     = $clog2(CHECK_LEN + 1);
  localparam int IDX_W     = $clog2(STORE_LEN);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic        frame_ok;
    logic        is_data_frame;
    logic [7:0]  frame_type;
    logic [15:0] app_id;
    logic [31:0] payload;
  } res_t;

endpackage

// ===== src/tfd_if.sv =====
interface tfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface tfd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic        is_data_frame;
  logic [7:0]  frame_type;
  logic [15:0] app_id;
  logic [31:0] payload;

  modport source (output valid, output frame_ok, output is_data_frame, output frame_type,
                  output app_id, output payload, input ready);
  modport sink (input valid, input frame_ok, input is_data_frame, input frame_type,
                input app_id, input payload, output ready);
endinterface

// ===== src/tfd_front.sv =====
module tfd_front #(
  parameter int RAW_CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  tfd_in_if.sink            in_ch,
  input  logic              q_full,
  output tfd_pkg::q_push_t  q_push
);

  localparam int RC_W = $clog2(RAW_CAPACITY + 1);

  logic [RC_W-1:0] raw_count_r, raw_count_nxt;
  logic            esc_r, esc_nxt;
  logic            accept;
  logic            room;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = raw_count_r < RC_W'(RAW_CAPACITY);

  // classify the transaction and unstuff raw bytes
  always_comb begin
    raw_count_nxt     = raw_count_r;
    esc_nxt           = esc_r;
    q_push.valid      = 1'b0;
    q_push.cmd.kind   = tfd_pkg::CMD_DATA;
    q_push.cmd.data   = in_ch.rx_byte;
    if (accept) begin
      case (in_ch.op)
        tfd_pkg::OP_START: begin
          raw_count_nxt   = '0;
          esc_nxt         = 1'b0;
          q_push.valid    = 1'b1;
          q_push.cmd.kind = tfd_pkg::CMD_CLEAR;
        end
        tfd_pkg::OP_BYTE: begin
          if (room) begin
            raw_count_nxt = raw_count_r + RC_W'(1);
            if (esc_r) begin
              esc_nxt         = 1'b0;
              q_push.valid    = 1'b1;
              q_push.cmd.data = in_ch.rx_byte ^ tfd_pkg::ESC_MASK;
            end else if (in_ch.rx_byte == tfd_pkg::ESC_BYTE) begin
              esc_nxt = 1'b1;
            end else begin
              q_push.valid = 1'b1;
            end
          end
        end
        tfd_pkg::OP_END: begin
          raw_count_nxt   = '0;
          esc_nxt         = 1'b0;
          q_push.valid    = 1'b1;
          q_push.cmd.kind = tfd_pkg::CMD_END;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_count_r <= '0;
      esc_r       <= 1'b0;
    end else begin
      raw_count_r <= raw_count_nxt;
      esc_r       <= esc_nxt;
    end
  end

endmodule

// ===== src/tfd_fifo.sv =====
module tfd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  tfd_pkg::q_push_t  push,
  output logic              full,
  output tfd_pkg::q_head_t  head,
  input  logic              pop
);

  tfd_pkg::cmd_t                  mem_r [tfd_pkg::QUEUE_DEPTH];
  logic [tfd_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tfd_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tfd_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           push_en;
  logic                           pop_en;

  assign full       = cnt_r == tfd_pkg::QCNT_W'(tfd_pkg::QUEUE_DEPTH);
  assign head.valid = cnt_r != '0;
  assign head.cmd   = mem_r[rd_ptr_r];
  assign push_en    = push.valid && !full;
  assign pop_en     = pop && head.valid;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_en) begin
      wr_ptr_nxt = (wr_ptr_r == tfd_pkg::QPTR_W'(tfd_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + tfd_pkg::QPTR_W'(1);
    end
    if (pop_en) begin
      rd_ptr_nxt = (rd_ptr_r == tfd_pkg::QPTR_W'(tfd_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + tfd_pkg::QPTR_W'(1);
    end
    if (push_en && !pop_en) begin
      cnt_nxt = cnt_r + tfd_pkg::QCNT_W'(1);
    end else if (pop_en && !push_en) begin
      cnt_nxt = cnt_r - tfd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

  // checks
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push.valid)
    else $error("command dropped: queue full");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tfd_pkg::QCNT_W'(tfd_pkg::QUEUE_DEPTH))
    else $error("queue occupancy out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");

endmodule

// ===== src/tfd_back.sv =====
module tfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tfd_pkg::q_head_t  head,
  output logic              pop,
  tfd_out_if.source         out_ch
);

  logic [tfd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                sum_r, sum_nxt;
  logic [7:0]                store_r [tfd_pkg::STORE_LEN];
  logic                      out_valid_r, out_valid_nxt;
  tfd_pkg::res_t             res_r, res_nxt;
  logic                      out_free;
  logic [8:0]                sum9;
  logic                      frame_ok;
  logic                      store_we;

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = head.valid && (head.cmd.kind != tfd_pkg::CMD_END || out_free);
  assign sum9     = {1'b0, sum_r} + {1'b0, head.cmd.data};
  assign frame_ok = (cnt_r == tfd_pkg::CNT_W'(tfd_pkg::CHECK_LEN)) &&
                    (sum_r == tfd_pkg::SUM_GOOD);
  assign store_we = pop && (head.cmd.kind == tfd_pkg::CMD_DATA) &&
                    (cnt_r < tfd_pkg::CNT_W'(tfd_pkg::STORE_LEN));

  // execute the queued command
  always_comb begin
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pop) begin
      case (head.cmd.kind)
        tfd_pkg::CMD_CLEAR: begin
          cnt_nxt = '0;
          sum_nxt = '0;
        end
        tfd_pkg::CMD_DATA: begin
          if (cnt_r < tfd_pkg::CNT_W'(tfd_pkg::CHECK_LEN)) begin
            // end-around carry
            sum_nxt = sum9[7:0] + {7'd0, sum9[8]};
            cnt_nxt = cnt_r + tfd_pkg::CNT_W'(1);
          end
        end
        tfd_pkg::CMD_END: begin
          res_nxt       = '0;
          out_valid_nxt = 1'b1;
          if (frame_ok) begin
            res_nxt.frame_ok      = 1'b1;
            res_nxt.is_data_frame = store_r[0] == tfd_pkg::DATA_TYPE;
            res_nxt.frame_type    = store_r[0];
            res_nxt.app_id        = {store_r[2], store_r[1]};
            res_nxt.payload       = {store_r[6], store_r[5], store_r[4], store_r[3]};
          end
          cnt_nxt = '0;
          sum_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame bytes and result register
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (store_we) begin
      store_r[cnt_r[tfd_pkg::IDX_W-1:0]] <= head.cmd.data;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_ok      = res_r.frame_ok;
  assign out_ch.is_data_frame = res_r.is_data_frame;
  assign out_ch.frame_type    = res_r.frame_type;
  assign out_ch.app_id        = res_r.app_id;
  assign out_ch.payload       = res_r.payload;

  // checks
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tfd_pkg::CNT_W'(tfd_pkg::CHECK_LEN))
    else $error("unstuffed count past check length");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.cmd.kind == tfd_pkg::CMD_END) |=> (cnt_r == '0 && sum_r == '0 && out_valid_r))
    else $error("frame state not cleared after end");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.frame_ok) |->
      (res_r.payload == '0 && res_r.app_id == '0 && res_r.frame_type == '0 &&
       !res_r.is_data_frame))
    else $error("failed frame carries nonzero fields");

endmodule

// ===== src/telemetry_frame_deframer_core.sv =====
// a frame end transaction goes into the command queue, and out valid is set when it
//   is popped; the pop waits while an earlier result still holds the output register
// throughput: one input transaction per cycle, set by the two-entry command queue
//   between the byte classifier and the sum/store engine; stalls only when it fills
// reset: synchronous active-low rst_n clears counters, escape flag, sum, queue and
//   output valid; stored frame bytes are only read after being written in a frame
module telemetry_frame_deframer_core #(
  parameter int RAW_CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tfd_in_if.sink      in_ch,
  tfd_out_if.source   out_ch
);

  tfd_pkg::q_push_t q_push;
  tfd_pkg::q_head_t q_head;
  logic             q_full;
  logic             q_pop;

  tfd_front #(
    .RAW_CAPACITY(RAW_CAPACITY)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  tfd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  tfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/telemetry_frame_deframer_core_tb.sv =====
module telemetry_frame_deframer_core_tb;

  localparam int RAW_CAP = 16;
  localparam int ITEM_TARGET = 1750;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // expected frame results, predicted from each accepted transaction
  class frame_scoreboard;
    logic [4:0]      raw_cnt;
    logic            esc_pend;
    logic [4:0]      unstuffed_cnt;
    logic [7:0]      sum_acc;
    logic [7:0]      frame_bytes[tfd_pkg::STORE_LEN];
    tfd_pkg::res_t   expected_frames[$];
    int              errors;
    int              n_results;
    int              n_good;

    function new();
      raw_cnt       = '0;
      esc_pend      = 1'b0;
      unstuffed_cnt = '0;
      sum_acc       = '0;
      errors        = 0;
      n_results     = 0;
      n_good        = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    function void clear_frame();
      raw_cnt       = '0;
      esc_pend      = 1'b0;
      unstuffed_cnt = '0;
      sum_acc       = '0;
    endfunction

    // store, sum and count one unstuffed byte
    function void deframe_byte(logic [7:0] b);
      logic [8:0] s;
      if (unstuffed_cnt < tfd_pkg::STORE_LEN)
        frame_bytes[unstuffed_cnt[tfd_pkg::IDX_W-1:0]] = b;
      if (unstuffed_cnt < tfd_pkg::CHECK_LEN) begin
        s = {1'b0, sum_acc} + {1'b0, b};
        s = {1'b0, s[7:0]} + {8'd0, s[8]};
        sum_acc = s[7:0];
      end
      if (unstuffed_cnt != 5'd31) unstuffed_cnt++;
    endfunction

    // build the result for a frame end and reset frame state
    function void close_frame();
      tfd_pkg::res_t r;
      r = '0;
      if (unstuffed_cnt >= tfd_pkg::CHECK_LEN && sum_acc == tfd_pkg::SUM_GOOD) begin
        r.frame_ok      = 1'b1;
        r.is_data_frame = (frame_bytes[0] == tfd_pkg::DATA_TYPE);
        r.frame_type    = frame_bytes[0];
        r.app_id        = {frame_bytes[2], frame_bytes[1]};
        r.payload       = {frame_bytes[6], frame_bytes[5], frame_bytes[4], frame_bytes[3]};
      end
      expected_frames.push_back(r);
      clear_frame();
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] b);
      case (op)
        tfd_pkg::OP_START: begin
          clear_frame();
        end
        tfd_pkg::OP_BYTE: begin
          if (raw_cnt < RAW_CAP) begin
            raw_cnt++;
            if (esc_pend) begin
              esc_pend = 1'b0;
              deframe_byte(b ^ tfd_pkg::ESC_MASK);
            end else if (b == tfd_pkg::ESC_BYTE) begin
              esc_pend = 1'b1;
            end else begin
              deframe_byte(b);
            end
          end
        end
        tfd_pkg::OP_END: begin
          close_frame();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(tfd_pkg::res_t got);
      tfd_pkg::res_t exp_r;
      if (expected_frames.size() == 0) begin
        $error("frame result with none expected: frame_ok %0d type %02h", got.frame_ok,
               got.frame_type);
        errors++;
        return;
      end
      exp_r = expected_frames.pop_front();
      n_results++;
      if (exp_r.frame_ok) n_good++;
      if (got.frame_ok !== exp_r.frame_ok) begin
        $error("frame_ok mismatch: expected %0d, actual %0d", exp_r.frame_ok, got.frame_ok);
        errors++;
      end
      if (got.is_data_frame !== exp_r.is_data_frame) begin
        $error("is_data_frame mismatch: expected %0d, actual %0d", exp_r.is_data_frame,
               got.is_data_frame);
        errors++;
      end
      if (got.frame_type !== exp_r.frame_type) begin
        $error("frame_type mismatch: expected %02h, actual %02h", exp_r.frame_type,
               got.frame_type);
        errors++;
      end
      if (got.app_id !== exp_r.app_id) begin
        $error("app_id mismatch: expected %04h, actual %04h", exp_r.app_id, got.app_id);
        errors++;
      end
      if (got.payload !== exp_r.payload) begin
        $error("payload mismatch: expected %08h, actual %08h", exp_r.payload, got.payload);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic calm = 1'b0;
  int   items_sent = 0;

  frame_scoreboard sb = new();

  tfd_in_if  in_if();
  tfd_out_if out_if();

  telemetry_frame_deframer_core #(
    .RAW_CAPACITY(RAW_CAP)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random back-pressure and checking of each transaction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result('{out_if.frame_ok, out_if.is_data_frame, out_if.frame_type,
                        out_if.app_id, out_if.payload});
    end
    out_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
  end

  // random byte with extra weight on the escape and escaped-escape values
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return tfd_pkg::ESC_BYTE;
    if (r < 22) return tfd_pkg::ESC_BYTE ^ tfd_pkg::ESC_MASK;
    if (r < 27) return 8'h00;
    if (r < 32) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic push_item(input logic [1:0] op, input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(op, b);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // stuff eight unstuffed bytes into raw bytes; escape_all stuffs every byte
  task automatic send_body(input logic [7:0] body[8], input bit escape_all);
    for (int i = 0; i < 8; i++) begin
      if (body[i] == tfd_pkg::ESC_BYTE || escape_all || $urandom_range(0, 99) < 5) begin
        push_item(tfd_pkg::OP_BYTE, tfd_pkg::ESC_BYTE);
        push_item(tfd_pkg::OP_BYTE, body[i] ^ tfd_pkg::ESC_MASK);
      end else begin
        push_item(tfd_pkg::OP_BYTE, body[i]);
      end
    end
  endtask

  // closing byte that brings the end-around sum to 0xff
  function automatic logic [7:0] sum_fill(input logic [7:0] body[8]);
    logic [8:0] s;
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 7; i++) begin
      s   = {1'b0, acc} + {1'b0, body[i]};
      acc = s[7:0] + {7'd0, s[8]};
    end
    return ~acc;
  endfunction

  // one random frame: mostly well formed, some corrupt, short, long or noise
  task automatic send_frame();
    logic [7:0] body[8];
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 85) push_item(tfd_pkg::OP_START, 8'($urandom_range(0, 255)));
    if (kind >= 90) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) push_item(2'($urandom_range(0, 3)), pick_byte());
      return;
    end
    if (kind >= 72 && kind < 82) begin
      n = $urandom_range(0, 7);
      for (int i = 0; i < n; i++) push_item(tfd_pkg::OP_BYTE, pick_byte());
      push_item(tfd_pkg::OP_END, 8'($urandom_range(0, 255)));
      return;
    end
    body[0] = ($urandom_range(0, 1) == 0) ? tfd_pkg::DATA_TYPE : pick_byte();
    for (int i = 1; i < 7; i++) body[i] = pick_byte();
    body[7] = sum_fill(body);
    // corrupt frame: set one body bit to the inverse of a random bit of that byte
    if (kind >= 60 && kind < 72) begin
      n = $urandom_range(0, 7);
      body[n][$urandom_range(0, 7)] = ~body[n][$urandom_range(0, 7)];
    end
    send_body(body, 1'b0);
    if ($urandom_range(0, 99) < 3) push_item(OP_UNUSED, pick_byte());
    // long frame: extra bytes past eight, possibly past raw capacity
    if (kind >= 82) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) push_item(tfd_pkg::OP_BYTE, pick_byte());
    end
    // trailing escape left pending at frame end
    if ($urandom_range(0, 99) < 5) push_item(tfd_pkg::OP_BYTE, tfd_pkg::ESC_BYTE);
    push_item(tfd_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [7:0] body[8];
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.op      <= tfd_pkg::OP_START;
    in_if.rx_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // data frame with no window start, escaped bytes and byte extremes
    body = '{tfd_pkg::DATA_TYPE, tfd_pkg::ESC_BYTE, 8'hFF, 8'h00, 8'h80, 8'h7E, 8'h01,
             8'h00};
    body[7] = sum_fill(body);
    send_body(body, 1'b0);
    push_item(tfd_pkg::OP_END, 8'hFF);
    // undefined op, then frame end with nothing received
    push_item(OP_UNUSED, 8'hFF);
    push_item(tfd_pkg::OP_END, 8'h00);
    // double escape, then a trailing escape at frame end
    push_item(tfd_pkg::OP_START, 8'h00);
    push_item(tfd_pkg::OP_BYTE, tfd_pkg::ESC_BYTE);
    push_item(tfd_pkg::OP_BYTE, tfd_pkg::ESC_BYTE);
    push_item(tfd_pkg::OP_BYTE, tfd_pkg::ESC_BYTE);
    push_item(tfd_pkg::OP_END, 8'h00);

    // random frames, with a stretch of no idling on either side
    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= 700 && items_sent < 1000);
      send_frame();
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d input transactions; checked %0d frame results, %0d with a good sum",
             items_sent, sb.n_results, sb.n_good);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 2000000);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/tfd_pkg.sv
src/tfd_if.sv
src/tfd_front.sv
src/tfd_fifo.sv
src/tfd_back.sv
src/telemetry_frame_deframer_core.sv
tb/telemetry_frame_deframer_core_tb.sv
